[rtl/pca_pkg.sv]
// Package: operation and status codes, FSM states and helpers for the palette allocator.
package pca_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_ALLOC_W = 3'd1,
      OP_FREE    = 3'd2,
      OP_STORE   = 3'd3,
      OP_QUERY   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_EXACT  = 3'd0,
      ST_NEW    = 3'd1,
      ST_APPROX = 3'd2,
      ST_FAIL   = 3'd3,
      ST_DONE   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_GRAY,
      S_SCAN_EX,
      S_SCAN_FR,
      S_SCAN_NR,
      S_SCAN_WAIT,
      S_RD_WAIT,
      S_MODIFY,
      S_OUT
   } state_type;

   localparam int REG_RED_BITS   = 0;
   localparam int REG_GREEN_BITS = 1;
   localparam int REG_BLUE_BITS  = 2;
   localparam int REG_GRAYSCALE  = 3;
   localparam int REG_ENTRIES    = 4;

   localparam logic [17:0] SUM_INIT = 18'd196608;

   function automatic logic [15:0] chan_mask(input logic [4:0] len);
      logic [4:0]  l;
      logic [16:0] m;
      begin
         l = (len > 5'd16) ? 5'd16 : len;
         m = 17'h1ffff << (5'd16 - l);
         chan_mask = m[15:0];
      end
   endfunction

   function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
      absdiff = (a > b) ? a - b : b - a;
   endfunction

endpackage

[rtl/palette_color_allocator_core.sv]
// Top level: reference-counted palette allocator with memory-backed entries.
//  channel | ports                  | direction
//  req     | req_valid/req_ready    | in
//  rsp     | rsp_valid/rsp_ready    | out
//  csr     | csr_write_enable/index | in
// An alloc scans the palette, one entry a cycle, in passes over the
// entries (exact, free, nearest). Free, store and query pass through the
// read-wait, modify and output states; a grey store first computes the grey
// level, and a rejected request goes straight to the output state. After
// reset a clearing pass zeroes the memory; no request is taken meanwhile. A
// stalled response holds the block in its output state until taken.
module palette_color_allocator_core #(
   parameter int PALETTE_DEPTH = 256,
   parameter int COUNT_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   input  logic [7:0]  req_pixel,
   input  logic        req_best_match,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   output logic        rsp_entry_written,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int EW = 48 + COUNT_WIDTH + 1;
   localparam int LW = AW + 1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

   logic [EW-1:0] mem [PALETTE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   logic [4:0] rbits_ff, gbits_ff, bbits_ff;
   logic       gray_ff;
   logic [8:0] entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rbits_ff <= 5'd8; gbits_ff <= 5'd8; bbits_ff <= 5'd8;
         gray_ff <= 1'b0; entries_ff <= 9'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            3'(pca_pkg::REG_RED_BITS):   rbits_ff <= csr_data[4:0];
            3'(pca_pkg::REG_GREEN_BITS): gbits_ff <= csr_data[4:0];
            3'(pca_pkg::REG_BLUE_BITS):  bbits_ff <= csr_data[4:0];
            3'(pca_pkg::REG_GRAYSCALE):  gray_ff  <= csr_data[0];
            3'(pca_pkg::REG_ENTRIES):    entries_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // search range: min(entries, depth, 256)
   logic [8:0] lim;
   always_comb begin
      lim = entries_ff;
      if (lim > 9'd256) lim = 9'd256;
      if (PALETTE_DEPTH < 256 && 32'(lim) > PALETTE_DEPTH) lim = 9'(PALETTE_DEPTH);
   end

   pca_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic [7:0]  px_ff, px_in;
   logic        bm_ff, bm_in;
   logic [LW-1:0] idx_ff, idx_in;      // address issued
   logic [LW-1:0] cmp_ff, cmp_in;      // address of rd_data_ff
   logic        cv_ff, cv_in;          // rd_data_ff valid for scan
   logic [17:0] best_ff, best_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic        bfound_ff, bfound_in;
   logic [17:0] gsum_ff, gsum_in;
   logic [7:0]  opx_ff, opx_in;
   logic [2:0]  ost_ff, ost_in;
   logic [15:0] or_ff, og_ff, ob_ff, or_in, og_in, ob_in;
   logic        ow_ff, ow_in;

   logic [15:0] e_r, e_g, e_b;
   logic [COUNT_WIDTH-1:0] e_cnt, cnt_inc;
   logic e_w;
   logic [17:0] near_sum;
   logic scan_end;

   assign e_r   = rd_data_ff[EW-1 -: 16];
   assign e_g   = rd_data_ff[EW-17 -: 16];
   assign e_b   = rd_data_ff[EW-33 -: 16];
   assign e_cnt = rd_data_ff[COUNT_WIDTH:1];
   assign e_w   = rd_data_ff[0];
   assign cnt_inc = (e_cnt == CMAX) ? e_cnt : e_cnt + 1'b1;
   assign near_sum = 18'(pca_pkg::absdiff(r_ff, e_r)) + 18'(pca_pkg::absdiff(g_ff, e_g))
                   + 18'(pca_pkg::absdiff(b_ff, e_b));
   assign scan_end = cv_ff && (32'(cmp_ff) + 1 >= 32'(lim));

   assign req_ready = (state_ff == pca_pkg::S_IDLE);
   assign rsp_valid = (state_ff == pca_pkg::S_OUT);
   assign rsp_pixel_out = opx_ff;
   assign rsp_status = ost_ff;
   assign rsp_red_out = or_ff;
   assign rsp_green_out = og_ff;
   assign rsp_blue_out = ob_ff;
   assign rsp_entry_written = ow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pca_pkg::S_CLEAR;
         idx_ff <= '0;
         cv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cv_ff <= cv_in;
      end
      op_ff <= op_in; r_ff <= r_in; g_ff <= g_in; b_ff <= b_in;
      px_ff <= px_in; bm_ff <= bm_in; cmp_ff <= cmp_in;
      best_ff <= best_in; bidx_ff <= bidx_in; bfound_ff <= bfound_in;
      gsum_ff <= gsum_in;
      opx_ff <= opx_in; ost_ff <= ost_in; or_ff <= or_in; og_ff <= og_in;
      ob_ff <= ob_in; ow_ff <= ow_in;
   end

   task automatic fail_out();
      opx_in = '0; ost_in = pca_pkg::ST_FAIL; or_in = '0; og_in = '0; ob_in = '0;
      ow_in = 1'b0;
      state_in = pca_pkg::S_OUT;
   endtask

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; r_in = r_ff; g_in = g_ff; b_in = b_ff; px_in = px_ff; bm_in = bm_ff;
      idx_in = idx_ff; cmp_in = idx_ff; cv_in = 1'b0;
      best_in = best_ff; bidx_in = bidx_ff; bfound_in = bfound_ff; gsum_in = gsum_ff;
      opx_in = opx_ff; ost_in = ost_ff; or_in = or_ff; og_in = og_ff; ob_in = ob_ff;
      ow_in = ow_ff;
      rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = '0;
      unique case (state_ff)
         pca_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == PALETTE_DEPTH - 1) begin
               idx_in = '0;
               state_in = pca_pkg::S_IDLE;
            end
         end
         pca_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation; px_in = req_pixel; bm_in = req_best_match;
               r_in = req_red; g_in = req_green; b_in = req_blue;
               best_in = pca_pkg::SUM_INIT; bfound_in = 1'b0;
               gsum_in = 18'(req_red) + 18'(req_green) + 18'(req_blue);
               if (req_operation == pca_pkg::OP_ALLOC) begin
                  r_in = req_red & pca_pkg::chan_mask(rbits_ff);
                  g_in = req_green & pca_pkg::chan_mask(gbits_ff);
                  b_in = req_blue & pca_pkg::chan_mask(bbits_ff);
                  idx_in = '0;
                  state_in = pca_pkg::S_SCAN_EX;
               end else if (req_operation == pca_pkg::OP_ALLOC_W) begin
                  idx_in = LW'(1);
                  state_in = pca_pkg::S_SCAN_FR;
               end else if (req_operation > pca_pkg::OP_QUERY || {1'b0, req_pixel} >= lim) begin
                  fail_out();
               end else begin
                  idx_in = LW'(req_pixel);
                  state_in = (req_operation == pca_pkg::OP_STORE && gray_ff)
                           ? pca_pkg::S_GRAY : pca_pkg::S_RD_WAIT;
               end
            end
         end
         pca_pkg::S_GRAY: begin
            // gsum < 3*65536: division by 3 by reciprocal
            r_in = 16'(({18'd0, gsum_ff} * 36'd174763) >> 19);
            g_in = r_in; b_in = r_in;
            state_in = pca_pkg::S_RD_WAIT;
         end
         pca_pkg::S_SCAN_EX, pca_pkg::S_SCAN_FR, pca_pkg::S_SCAN_NR: begin
            if (32'(idx_ff) < 32'(lim)) begin
               cv_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (cv_ff) begin
               priority case (state_ff)
                  pca_pkg::S_SCAN_EX: if (!e_w && e_r == r_ff && e_g == g_ff && e_b == b_ff) begin
                     cv_in = 1'b0; idx_in = cmp_ff; state_in = pca_pkg::S_SCAN_WAIT;
                  end
                  pca_pkg::S_SCAN_FR: if (e_cnt == '0) begin
                     cv_in = 1'b0; idx_in = cmp_ff; state_in = pca_pkg::S_SCAN_WAIT;
                  end
                  default: if (!e_w && near_sum < best_ff) begin
                     best_in = near_sum; bidx_in = cmp_ff[AW-1:0]; bfound_in = 1'b1;
                  end
               endcase
            end
            if (state_in == state_ff && (scan_end || (!cv_ff && 32'(idx_ff) >= 32'(lim)))) begin
               cv_in = 1'b0;
               priority case (state_ff)
                  pca_pkg::S_SCAN_EX: begin
                     idx_in = '0; state_in = pca_pkg::S_SCAN_FR;
                  end
                  pca_pkg::S_SCAN_FR: begin
                     if (op_ff == pca_pkg::OP_ALLOC && bm_ff) begin
                        idx_in = '0; state_in = pca_pkg::S_SCAN_NR;
                     end else fail_out();
                  end
                  default: begin
                     if (bfound_in) begin
                        idx_in = LW'(bidx_in); state_in = pca_pkg::S_SCAN_WAIT;
                     end else fail_out();
                  end
               endcase
            end
            if (state_in == pca_pkg::S_SCAN_WAIT) begin
               priority case (state_ff)
                  pca_pkg::S_SCAN_EX: ost_in = pca_pkg::ST_EXACT;
                  pca_pkg::S_SCAN_FR: ost_in = pca_pkg::ST_NEW;
                  default: ost_in = pca_pkg::ST_APPROX;
               endcase
            end
         end
         pca_pkg::S_SCAN_WAIT: state_in = pca_pkg::S_MODIFY;
         pca_pkg::S_RD_WAIT: begin
            ost_in = pca_pkg::ST_DONE;
            state_in = pca_pkg::S_MODIFY;
         end
         pca_pkg::S_MODIFY: begin
            wr_addr = idx_ff[AW-1:0];
            opx_in = 8'(idx_ff);
            or_in = e_r; og_in = e_g; ob_in = e_b; ow_in = 1'b0;
            wr_data = rd_data_ff;
            unique case (op_ff)
               pca_pkg::OP_ALLOC: begin
                  wr_en = 1'b1;
                  if (ost_ff == pca_pkg::ST_NEW) begin
                     wr_data = {r_ff, g_ff, b_ff, COUNT_WIDTH'(1), 1'b0};
                     or_in = r_ff; og_in = g_ff; ob_in = b_ff; ow_in = 1'b1;
                  end else wr_data = {e_r, e_g, e_b, cnt_inc, e_w};
               end
               pca_pkg::OP_ALLOC_W: begin
                  wr_en = 1'b1;
                  wr_data = {e_r, e_g, e_b, COUNT_WIDTH'(1), 1'b1};
               end
               pca_pkg::OP_FREE: begin
                  wr_en = 1'b1;
                  if (e_cnt != '0)
                     wr_data = {e_r, e_g, e_b, e_cnt - 1'b1,
                                (e_cnt == COUNT_WIDTH'(1)) ? 1'b0 : e_w};
               end
               pca_pkg::OP_STORE: begin
                  wr_en = 1'b1;
                  wr_data = {r_ff, g_ff, b_ff, e_cnt, e_w};
                  or_in = r_ff; og_in = g_ff; ob_in = b_ff; ow_in = 1'b1;
               end
               default: ;
            endcase
            state_in = pca_pkg::S_OUT;
         end
         pca_pkg::S_OUT: if (rsp_ready) state_in = pca_pkg::S_IDLE;
         default: state_in = pca_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pca_pkg::ST_FAIL |-> rsp_pixel_out == '0 && !rsp_entry_written)
      else $error("failed response carries data");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken during response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("response dropped");
`endif

endmodule
